/* src/skrg_pkg.sv */
`default_nettype none
package skrg_pkg;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef struct packed {
		logic        op;
		logic [15:0] group_key;
		logic [15:0] scan_index;
	} req_t;

	typedef struct packed {
		logic [4:0]  slot;
		logic [15:0] key_out;
		logic [4:0]  group_number;
		logic [4:0]  group_start;
		logic        first_in_group;
		logic        last_in_group;
		logic [5:0]  member_count;
		logic        overflow;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic drain;
	} cell_ctrl_t;

endpackage
`default_nettype wire

/* src/skrg_cell.sv */
`default_nettype none
module skrg_cell #(
	parameter int KEY_BITS = 16,
	parameter int SLOT_W   = 5,
	parameter int CNT_W    = 6,
	parameter int IDX      = 0
) (
	input  wire                      clk,
	input  wire skrg_pkg::cell_ctrl_t ctrl,
	input  wire [CNT_W-1:0]          count,
	input  wire [KEY_BITS-1:0]       new_key,
	input  wire [15:0]               new_scan,
	input  wire [SLOT_W-1:0]         new_slot,
	input  wire                      prev_ins,
	input  wire [KEY_BITS-1:0]       prev_key,
	input  wire [15:0]               prev_scan,
	input  wire [SLOT_W-1:0]         prev_slot,
	input  wire [KEY_BITS-1:0]       next_key,
	input  wire [15:0]               next_scan,
	input  wire [SLOT_W-1:0]         next_slot,
	output logic                     ins,
	output logic [KEY_BITS-1:0]      key_q,
	output logic [15:0]              scan_q,
	output logic [SLOT_W-1:0]        slot_q
);

	logic occupied;
	logic stays;

	always_comb begin
		occupied = count > CNT_W'(IDX);
		if (key_q != new_key) begin
			stays = key_q < new_key;
		end else begin
			stays = scan_q <= new_scan;
		end
		ins = !occupied || !stays;
	end

	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			key_q  <= next_key;
			scan_q <= next_scan;
			slot_q <= next_slot;
		end else if (ctrl.load && ins) begin
			if (prev_ins) begin
				key_q  <= prev_key;
				scan_q <= prev_scan;
				slot_q <= prev_slot;
			end else begin
				key_q  <= new_key;
				scan_q <= new_scan;
				slot_q <= new_slot;
			end
		end
	end

endmodule
`default_nettype wire

/* src/stable_key_sort_run_grouper.sv */
// Load: one request per cycle, busy stays low; the entry is placed in the cell chain
// at the clock edge that accepts it. Finish: busy while the N loaded entries are sent, one
// result per cycle from the head cell; an accepted finish moves the block into its emit
// state, from which each result is registered. A finish on an empty set gives no result.
// Reset (arst_n low) empties the set and clears the overflow mark; the receiver cannot stall.
`default_nettype none
module stable_key_sort_run_grouper #(
	parameter int CAPACITY = 32,
	parameter int KEY_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire skrg_pkg::req_t req,
	output logic                rsp_valid,
	output skrg_pkg::rsp_t      rsp
);

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic                 dropped_q;
	logic [CNT_W-1:0]     pos_q;
	logic [CNT_W-1:0]     grp_q;
	logic [CNT_W-1:0]     gstart_q;

	skrg_pkg::cell_ctrl_t ctrl;
	logic                 accept;
	logic                 full;
	logic [KEY_BITS-1:0]  new_key;

	logic                 ins_w  [CAPACITY];
	logic [KEY_BITS-1:0]  key_w  [CAPACITY];
	logic [15:0]          scan_w [CAPACITY];
	logic [SLOT_W-1:0]    slot_w [CAPACITY];

	logic                 head_last;
	logic                 burst_last;
	logic [CNT_W-1:0]     pos_next;

	assign busy    = state_q == ST_EMIT;
	assign accept  = start && !busy;
	assign full    = count_q == CNT_W'(CAPACITY);
	assign new_key = KEY_BITS'(req.group_key);

	always_comb begin
		ctrl.load  = accept && req.op == skrg_pkg::OP_LOAD && !full;
		ctrl.drain = state_q == ST_EMIT;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                prev_ins;
		logic [KEY_BITS-1:0] prev_key;
		logic [15:0]         prev_scan;
		logic [SLOT_W-1:0]   prev_slot;
		logic [KEY_BITS-1:0] next_key;
		logic [15:0]         next_scan;
		logic [SLOT_W-1:0]   next_slot;

		if (i == 0) begin : g_head
			assign prev_ins  = 1'b0;
			assign prev_key  = '0;
			assign prev_scan = '0;
			assign prev_slot = '0;
		end else begin : g_body
			assign prev_ins  = ins_w[i-1];
			assign prev_key  = key_w[i-1];
			assign prev_scan = scan_w[i-1];
			assign prev_slot = slot_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_key  = key_w[i];
			assign next_scan = scan_w[i];
			assign next_slot = slot_w[i];
		end else begin : g_mid
			assign next_key  = key_w[i+1];
			assign next_scan = scan_w[i+1];
			assign next_slot = slot_w[i+1];
		end

		skrg_cell #(
			.KEY_BITS (KEY_BITS),
			.SLOT_W   (SLOT_W),
			.CNT_W    (CNT_W),
			.IDX      (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (count_q),
			.new_key   (new_key),
			.new_scan  (req.scan_index),
			.new_slot  (count_q[SLOT_W-1:0]),
			.prev_ins  (prev_ins),
			.prev_key  (prev_key),
			.prev_scan (prev_scan),
			.prev_slot (prev_slot),
			.next_key  (next_key),
			.next_scan (next_scan),
			.next_slot (next_slot),
			.ins       (ins_w[i]),
			.key_q     (key_w[i]),
			.scan_q    (scan_w[i]),
			.slot_q    (slot_w[i])
		);
	end

	always_comb begin
		pos_next   = pos_q + CNT_W'(1);
		burst_last = pos_next == count_q;
		head_last  = burst_last || key_w[1] != key_w[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			dropped_q <= 1'b0;
			pos_q     <= '0;
			grp_q     <= '0;
			gstart_q  <= '0;
			rsp_valid <= 1'b0;
			rsp       <= '0;
		end else begin
			rsp_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.op == skrg_pkg::OP_LOAD) begin
							if (full) begin
								dropped_q <= 1'b1;
							end else begin
								count_q <= count_q + CNT_W'(1);
							end
						end else if (count_q == '0) begin
							dropped_q <= 1'b0;
						end else begin
							state_q  <= ST_EMIT;
							pos_q    <= '0;
							grp_q    <= '0;
							gstart_q <= '0;
						end
					end
				end
				ST_EMIT: begin
					rsp_valid           <= 1'b1;
					rsp.slot            <= 5'(slot_w[0]);
					rsp.key_out         <= 16'(key_w[0]);
					rsp.group_number    <= 5'(grp_q);
					rsp.group_start     <= 5'(gstart_q);
					rsp.first_in_group  <= pos_q == gstart_q;
					rsp.last_in_group   <= head_last;
					rsp.member_count    <= head_last ? 6'(pos_next - gstart_q) : '0;
					rsp.overflow        <= dropped_q;
					rsp.last            <= burst_last;
					pos_q               <= pos_next;
					if (head_last) begin
						grp_q    <= grp_q + CNT_W'(1);
						gstart_q <= pos_next;
					end
					if (burst_last) begin
						state_q   <= ST_IDLE;
						count_q   <= '0;
						dropped_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

	localparam int SLOTS = 32;
	localparam int DIR_ROWS = 18;
	localparam int RAND_LOADS = 80;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		bit             typed;
		skrg_pkg::req_t r;
		skrg_pkg::rsp_t exp;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	skrg_pkg::req_t req = '0;
	logic rsp_valid;
	skrg_pkg::rsp_t rsp;

	logic [15:0]    sorted_key [SLOTS];
	logic [15:0]    sorted_scan [SLOTS];
	logic [4:0]     sorted_slot [SLOTS];
	int             held_count = 0;
	bit             dropped_seen = 1'b0;
	skrg_pkg::rsp_t grouped_q [$];

	int mismatch_cnt = 0;
	int stall_cycles = 0;
	int sender_idle_pct = 29;

	row_t dir_tab [0:DIR_ROWS-1] = '{
		{1'b0, skrg_pkg::OP_FINISH, 16'hFFFF, 16'hFFFF, 41'd0},
		{1'b0, skrg_pkg::OP_LOAD,   16'hFFFF, 16'hFFFF, 41'd0},
		{1'b1, skrg_pkg::OP_FINISH, 16'h1234, 16'h5678,
			5'd0, 16'hFFFF, 5'd0, 5'd0, 1'b1, 1'b1, 6'd1, 1'b0, 1'b1},
		{1'b0, skrg_pkg::OP_LOAD,   16'h0000, 16'h0000, 41'd0},
		{1'b1, skrg_pkg::OP_FINISH, 16'h0000, 16'h0000,
			5'd0, 16'h0000, 5'd0, 5'd0, 1'b1, 1'b1, 6'd1, 1'b0, 1'b1},
		{1'b0, skrg_pkg::OP_LOAD,   16'h0005, 16'h0009, 41'd0},
		{1'b0, skrg_pkg::OP_LOAD,   16'h0005, 16'h0009, 41'd0},
		{1'b0, skrg_pkg::OP_LOAD,   16'h0005, 16'h0003, 41'd0},
		{1'b0, skrg_pkg::OP_LOAD,   16'h0000, 16'hFFFF, 41'd0},
		{1'b0, skrg_pkg::OP_LOAD,   16'hFFFF, 16'h0000, 41'd0},
		{1'b0, skrg_pkg::OP_LOAD,   16'h0005, 16'h0009, 41'd0},
		{1'b0, skrg_pkg::OP_FINISH, 16'hA5A5, 16'h5A5A, 41'd0},
		{1'b0, skrg_pkg::OP_LOAD,   16'hAAAA, 16'h5555, 41'd0},
		{1'b0, skrg_pkg::OP_LOAD,   16'h5555, 16'hAAAA, 41'd0},
		{1'b0, skrg_pkg::OP_LOAD,   16'h1234, 16'h0000, 41'd0},
		{1'b0, skrg_pkg::OP_LOAD,   16'h1234, 16'h0000, 41'd0},
		{1'b0, skrg_pkg::OP_FINISH, 16'h0000, 16'hFFFF, 41'd0},
		{1'b0, skrg_pkg::OP_FINISH, 16'h0001, 16'h0001, 41'd0}
	};

	stable_key_sort_run_grouper i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic sort_and_group(input skrg_pkg::req_t r, input bit keep);
		int pos, i, j, grp, first, n;
		skrg_pkg::rsp_t e;
		if (r.op == skrg_pkg::OP_LOAD) begin
			if (held_count >= SLOTS) begin
				dropped_seen = 1'b1;
				return;
			end
			pos = held_count;
			while (pos > 0 && (sorted_key[pos-1] > r.group_key ||
					(sorted_key[pos-1] == r.group_key &&
					sorted_scan[pos-1] > r.scan_index))) begin
				sorted_key[pos]  = sorted_key[pos-1];
				sorted_scan[pos] = sorted_scan[pos-1];
				sorted_slot[pos] = sorted_slot[pos-1];
				pos--;
			end
			sorted_key[pos]  = r.group_key;
			sorted_scan[pos] = r.scan_index;
			sorted_slot[pos] = 5'(held_count);
			held_count++;
		end else begin
			n = held_count;
			grp = 0;
			i = 0;
			while (i < n) begin
				first = i;
				j = i + 1;
				while (j < n && sorted_key[j] == sorted_key[first])
					j++;
				for (; i < j; i++) begin
					e.slot           = sorted_slot[i];
					e.key_out        = sorted_key[i];
					e.group_number   = 5'(grp);
					e.group_start    = 5'(first);
					e.first_in_group = (i == first);
					e.last_in_group  = (i + 1 == j);
					e.member_count   = (i + 1 == j) ? 6'(j - first) : 6'd0;
					e.overflow       = dropped_seen;
					e.last           = (i + 1 == n);
					if (keep)
						grouped_q.push_back(e);
				end
				grp++;
			end
			held_count = 0;
			dropped_seen = 1'b0;
		end
	endtask

	task automatic send_request(input skrg_pkg::req_t r, input bit keep);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sort_and_group(r, keep);
	endtask

	function automatic logic [15:0] pick_field();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(0, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic note_mismatch(input string what, input skrg_pkg::rsp_t want,
			input skrg_pkg::rsp_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			$display("%0t %s", $realtime, what);
			$display("  expected slot=%0d key=%h grp=%0d start=%0d first=%0d lst=%0d",
				want.slot, want.key_out, want.group_number, want.group_start,
				want.first_in_group, want.last_in_group);
			$display("           cnt=%0d ovf=%0d last=%0d",
				want.member_count, want.overflow, want.last);
			$display("  actual   slot=%0d key=%h grp=%0d start=%0d first=%0d lst=%0d",
				got.slot, got.key_out, got.group_number, got.group_start,
				got.first_in_group, got.last_in_group);
			$display("           cnt=%0d ovf=%0d last=%0d",
				got.member_count, got.overflow, got.last);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid) begin
			if (grouped_q.size() == 0)
				note_mismatch("result with nothing pending", '0, rsp);
			else if (rsp !== grouped_q[0])
				note_mismatch("result differs", grouped_q.pop_front(), rsp);
			else
				void'(grouped_q.pop_front());
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || rsp_valid)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		skrg_pkg::req_t r;
		int set_no, set_size, loads_done;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < DIR_ROWS; k++) begin
			send_request(dir_tab[k].r, !dir_tab[k].typed);
			if (dir_tab[k].typed)
				grouped_q.push_back(dir_tab[k].exp);
		end

		set_no = 0;
		loads_done = 0;
		while (loads_done < RAND_LOADS) begin
			sender_idle_pct = (loads_done < RAND_LOADS / 3) ? 29 :
				(loads_done < 2 * RAND_LOADS / 3) ? 64 : 0;
			if (set_no == 1)
				set_size = $urandom_range(SLOTS + 1, SLOTS + 4);
			else if (set_no == 4)
				set_size = SLOTS;
			else
				set_size = $urandom_range(0, 8);
			repeat (set_size) begin
				r.op = skrg_pkg::OP_LOAD;
				r.group_key = pick_field();
				r.scan_index = pick_field();
				send_request(r, 1'b1);
			end
			loads_done += set_size;
			r.op = skrg_pkg::OP_FINISH;
			r.group_key = 16'($urandom);
			r.scan_index = 16'($urandom);
			send_request(r, 1'b1);
			set_no++;
		end
		@(negedge clk);
		start <= 1'b0;

		while (grouped_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
